@@ src/look_at_view_matrix_defines.svh @@
// Assertion helpers for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LAV_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LAV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lav_pkg.sv @@
package lav_pkg;

  localparam int Q_DEPTH = 2;
  localparam int NV_W    = 52;
  localparam int ACC_W   = 52;
  localparam int AX_W    = 18;
  localparam int Y_W     = 19;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // operand A codes
  localparam logic [3:0] A_UP0  = 4'd0;
  localparam logic [3:0] A_UP1  = 4'd1;
  localparam logic [3:0] A_UP2  = 4'd2;
  localparam logic [3:0] A_EYE0 = 4'd3;
  localparam logic [3:0] A_EYE1 = 4'd4;
  localparam logic [3:0] A_EYE2 = 4'd5;
  localparam logic [3:0] A_Z0   = 4'd6;
  localparam logic [3:0] A_Z1   = 4'd7;
  localparam logic [3:0] A_Z2   = 4'd8;

  // operand B codes
  localparam logic [3:0] B_Z0 = 4'd0;
  localparam logic [3:0] B_Z1 = 4'd1;
  localparam logic [3:0] B_Z2 = 4'd2;
  localparam logic [3:0] B_X0 = 4'd3;
  localparam logic [3:0] B_X1 = 4'd4;
  localparam logic [3:0] B_X2 = 4'd5;
  localparam logic [3:0] B_Y0 = 4'd6;
  localparam logic [3:0] B_Y1 = 4'd7;
  localparam logic [3:0] B_Y2 = 4'd8;

  localparam logic [4:0] MAC_LAST_STEP = 5'd20;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] d;
  } lav_item_t;

  typedef struct packed {
    logic      valid;
    lav_item_t item;
  } lav_head_t;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [3:0] b_sel;
    logic       neg;
    logic       last;
  } mac_op_t;

  function automatic mac_op_t mk_op(input logic [3:0] a, input logic [3:0] b,
                                    input logic neg, input logic last);
    mac_op_t o;
    o.a_sel = a;
    o.b_sel = b;
    o.neg   = neg;
    o.last  = last;
    return o;
  endfunction

  // up cross z, z cross x, then the three translation dots
  function automatic mac_op_t mac_op(input logic [4:0] step);
    mac_op_t o;
    unique case (step)
      5'd0:  o = mk_op(A_UP1, B_Z2, 1'b0, 1'b0);
      5'd1:  o = mk_op(A_UP2, B_Z1, 1'b1, 1'b1);
      5'd2:  o = mk_op(A_UP2, B_Z0, 1'b0, 1'b0);
      5'd3:  o = mk_op(A_UP0, B_Z2, 1'b1, 1'b1);
      5'd4:  o = mk_op(A_UP0, B_Z1, 1'b0, 1'b0);
      5'd5:  o = mk_op(A_UP1, B_Z0, 1'b1, 1'b1);
      5'd6:  o = mk_op(A_Z1, B_X2, 1'b0, 1'b0);
      5'd7:  o = mk_op(A_Z2, B_X1, 1'b1, 1'b1);
      5'd8:  o = mk_op(A_Z2, B_X0, 1'b0, 1'b0);
      5'd9:  o = mk_op(A_Z0, B_X2, 1'b1, 1'b1);
      5'd10: o = mk_op(A_Z0, B_X1, 1'b0, 1'b0);
      5'd11: o = mk_op(A_Z1, B_X0, 1'b1, 1'b1);
      5'd12: o = mk_op(A_EYE0, B_X0, 1'b0, 1'b0);
      5'd13: o = mk_op(A_EYE1, B_X1, 1'b0, 1'b0);
      5'd14: o = mk_op(A_EYE2, B_X2, 1'b0, 1'b1);
      5'd15: o = mk_op(A_EYE0, B_Y0, 1'b0, 1'b0);
      5'd16: o = mk_op(A_EYE1, B_Y1, 1'b0, 1'b0);
      5'd17: o = mk_op(A_EYE2, B_Y2, 1'b0, 1'b1);
      5'd18: o = mk_op(A_EYE0, B_Z0, 1'b0, 1'b0);
      5'd19: o = mk_op(A_EYE1, B_Z1, 1'b0, 1'b0);
      5'd20: o = mk_op(A_EYE2, B_Z2, 1'b0, 1'b1);
      default: o = mk_op(A_UP0, B_Z0, 1'b0, 1'b0);
    endcase
    return o;
  endfunction

  // Q20.32 to Q36.16, half away from zero
  function automatic logic [ACC_W-1:0] round16(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] q;
    m = v[ACC_W-1] ? (~v + 1'b1) : v;
    q = (m + ACC_W'(32768)) >> 16;
    return v[ACC_W-1] ? (~q + 1'b1) : q;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > ACC_W'(signed'(33'sh0_7FFF_FFFF)))
      r = 32'h7FFF_FFFF;
    else if (v < ACC_W'(signed'(33'sh1_8000_0000)))
      r = 32'h8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage

@@ src/lav_front.sv @@
module lav_front
  import lav_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_eye_x,
  input  logic [31:0] in_eye_y,
  input  logic [31:0] in_eye_z,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_z,
  input  logic [31:0] in_up_x,
  input  logic [31:0] in_up_y,
  input  logic [31:0] in_up_z,
  input  logic        pop,
  output lav_head_t   head
);

  lav_item_t q_r [Q_DEPTH];
  logic      wr_r;
  logic      rd_r;
  logic [1:0] cnt_r;
  lav_item_t item;
  logic      push;

  assign busy = (cnt_r == 2'(Q_DEPTH));
  assign push = start && !busy;

  // form the view direction while taking the word in
  always_comb begin
    item.eye = {in_eye_z, in_eye_y, in_eye_x};
    item.up  = {in_up_z, in_up_y, in_up_x};
    item.d[0] = {in_eye_x[31], in_eye_x} - {in_target_x[31], in_target_x};
    item.d[1] = {in_eye_y[31], in_eye_y} - {in_target_y[31], in_target_y};
    item.d[2] = {in_eye_z[31], in_eye_z} - {in_target_z[31], in_target_z};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_r];

endmodule

@@ src/lav_norm.sv @@
module lav_norm
  import lav_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [2:0][NV_W-1:0]      vec,
  output logic                      done,
  output logic                      zero,
  output logic [2:0][AX_W-1:0]      res
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;

  logic [2:0]            st_r;
  logic [NV_W-1:0]       m_r [3];
  logic [2:0]            sgn_r;
  logic [4:0]            cnt_r;
  logic [1:0]            k_r;
  logic [59:0]           prod_r;
  logic [61:0]           sum_r;
  logic [63:0]           n_r;
  logic [63:0]           res_r;
  logic [63:0]           bit_r;
  logic [30:0]           len_r;
  logic [31:0]           rem_r;
  logic [17:0]           lo_r;
  logic [AX_W-1:0]       q_r;
  logic [2:0][AX_W-1:0]  out_r;
  logic                  zero_r;
  logic                  done_r;

  logic [NV_W-1:0]       mag_in [3];
  logic [NV_W-1:0]       orv;
  logic [63:0]           trial;
  logic [63:0]           sq_res_nxt;
  logic                  sq_take;
  logic [31:0]           shifted;
  logic                  ge;
  logic [AX_W-1:0]       q_nxt;
  logic [46:0]           num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec[i][NV_W-1] ? (~vec[i] + 1'b1) : vec[i];
    end
    orv        = m_r[0] | m_r[1] | m_r[2];
    trial      = res_r + bit_r;
    sq_take    = (n_r >= trial);
    sq_res_nxt = sq_take ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    shifted    = {rem_r[30:0], lo_r[17]};
    ge         = (shifted >= {1'b0, len_r});
    q_nxt      = {q_r[AX_W-2:0], ge};
    num        = {1'b0, m_r[k_r][29:0], 16'b0} + {17'b0, len_r[30:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        N_IDLE: begin
          if (go) begin
            for (int i = 0; i < 3; i++) begin
              m_r[i]   <= mag_in[i];
              sgn_r[i] <= vec[i][NV_W-1];
            end
            if ((mag_in[0] | mag_in[1] | mag_in[2]) == '0) begin
              out_r  <= '0;
              zero_r <= 1'b1;
              done_r <= 1'b1;
            end else begin
              zero_r <= 1'b0;
              st_r   <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (orv[NV_W-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!orv[29]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            st_r  <= N_SQ;
            k_r   <= '0;
            sum_r <= '0;
          end
        end
        N_SQ: begin
          if (k_r != 2'd3) begin
            prod_r <= m_r[k_r][29:0] * m_r[k_r][29:0];
          end
          if (k_r != 2'd0) begin
            sum_r <= sum_r + 62'(prod_r);
          end
          if (k_r == 2'd3) begin
            n_r   <= 64'(sum_r + 62'(prod_r));
            res_r <= '0;
            bit_r <= 64'(1) << 62;
            cnt_r <= '0;
            st_r  <= N_SQRT;
          end
          k_r <= k_r + 1'b1;
        end
        N_SQRT: begin
          if (sq_take) begin
            n_r <= n_r - trial;
          end
          res_r <= sq_res_nxt;
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) begin
            len_r <= sq_res_nxt[30:0];
            cnt_r <= '0;
            k_r   <= '0;
            st_r  <= N_DIV;
          end
        end
        N_DIV: begin
          if (cnt_r == 5'd0) begin
            rem_r <= {3'b0, num[46:18]};
            lo_r  <= num[17:0];
            q_r   <= '0;
            cnt_r <= 5'd1;
          end else begin
            rem_r <= ge ? (shifted - {1'b0, len_r}) : shifted;
            lo_r  <= lo_r << 1;
            q_r   <= q_nxt;
            if (cnt_r == 5'd18) begin
              out_r[k_r] <= sgn_r[k_r] ? (~q_nxt + 1'b1) : q_nxt;
              cnt_r      <= '0;
              if (k_r == 2'd2) begin
                st_r   <= N_IDLE;
                done_r <= 1'b1;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign zero = zero_r;
  assign res  = out_r;

endmodule

@@ src/lav_back.sv @@
module lav_back
  import lav_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lav_head_t   head,
  output logic        pop,
  output logic        out_valid,
  output logic [3:0]  out_entry_index,
  output logic [31:0] out_entry_value,
  output logic        out_last_entry,
  output logic        out_degenerate
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_NZ   = 3'd1;
  localparam logic [2:0] B_MAC  = 3'd2;
  localparam logic [2:0] B_NX   = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  logic [2:0]                st_r;
  lav_item_t                 item_r;
  logic                      go_r;
  logic [4:0]                step_r;
  logic [3:0]                g_r;
  logic                      ph_r;
  logic signed [50:0]        p_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [2:0][AX_W-1:0]      za_r;
  logic [2:0][AX_W-1:0]      xa_r;
  logic [2:0][Y_W-1:0]       ya_r;
  logic [2:0][NV_W-1:0]      cr_r;
  logic [2:0][31:0]          t_r;
  logic                      degen_r;
  logic [3:0]                idx_r;
  logic                      ov_r;
  logic [3:0]                oi_r;
  logic [31:0]               ovl_r;
  logic                      ol_r;
  logic                      od_r;

  logic [2:0][NV_W-1:0]      nvec;
  logic                      n_done;
  logic                      n_zero;
  logic [2:0][AX_W-1:0]      n_res;
  mac_op_t                   op;
  logic [31:0]               a_op;
  logic [Y_W-1:0]            b_op;
  logic signed [ACC_W-1:0]   accv;
  logic [ACC_W-1:0]          rnd;
  logic [31:0]               word;

  lav_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .vec   (nvec),
    .done  (n_done),
    .zero  (n_zero),
    .res   (n_res)
  );

  assign pop = (st_r == B_IDLE) && head.valid;

  always_comb begin
    if (st_r == B_NZ) begin
      for (int i = 0; i < 3; i++) begin
        nvec[i] = {{(NV_W-33){item_r.d[i][32]}}, item_r.d[i]};
      end
    end else begin
      nvec = cr_r;
    end
  end

  always_comb begin
    op = mac_op(step_r);
    unique case (op.a_sel)
      A_UP0:  a_op = item_r.up[0];
      A_UP1:  a_op = item_r.up[1];
      A_UP2:  a_op = item_r.up[2];
      A_EYE0: a_op = item_r.eye[0];
      A_EYE1: a_op = item_r.eye[1];
      A_EYE2: a_op = item_r.eye[2];
      A_Z0:   a_op = {{(32-AX_W){za_r[0][AX_W-1]}}, za_r[0]};
      A_Z1:   a_op = {{(32-AX_W){za_r[1][AX_W-1]}}, za_r[1]};
      A_Z2:   a_op = {{(32-AX_W){za_r[2][AX_W-1]}}, za_r[2]};
      default: a_op = '0;
    endcase
    unique case (op.b_sel)
      B_Z0: b_op = {za_r[0][AX_W-1], za_r[0]};
      B_Z1: b_op = {za_r[1][AX_W-1], za_r[1]};
      B_Z2: b_op = {za_r[2][AX_W-1], za_r[2]};
      B_X0: b_op = {xa_r[0][AX_W-1], xa_r[0]};
      B_X1: b_op = {xa_r[1][AX_W-1], xa_r[1]};
      B_X2: b_op = {xa_r[2][AX_W-1], xa_r[2]};
      B_Y0: b_op = ya_r[0];
      B_Y1: b_op = ya_r[1];
      B_Y2: b_op = ya_r[2];
      default: b_op = '0;
    endcase
    accv = op.neg ? (acc_r - ACC_W'(p_r)) : (acc_r + ACC_W'(p_r));
    rnd  = round16(accv);
  end

  always_comb begin
    unique case (idx_r)
      4'd0:  word = {{(32-AX_W){xa_r[0][AX_W-1]}}, xa_r[0]};
      4'd1:  word = {{(32-Y_W){ya_r[0][Y_W-1]}}, ya_r[0]};
      4'd2:  word = {{(32-AX_W){za_r[0][AX_W-1]}}, za_r[0]};
      4'd4:  word = {{(32-AX_W){xa_r[1][AX_W-1]}}, xa_r[1]};
      4'd5:  word = {{(32-Y_W){ya_r[1][Y_W-1]}}, ya_r[1]};
      4'd6:  word = {{(32-AX_W){za_r[1][AX_W-1]}}, za_r[1]};
      4'd8:  word = {{(32-AX_W){xa_r[2][AX_W-1]}}, xa_r[2]};
      4'd9:  word = {{(32-Y_W){ya_r[2][Y_W-1]}}, ya_r[2]};
      4'd10: word = {{(32-AX_W){za_r[2][AX_W-1]}}, za_r[2]};
      4'd12: word = t_r[0];
      4'd13: word = t_r[1];
      4'd14: word = t_r[2];
      4'd15: word = ONE_Q16;
      default: word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      go_r   <= 1'b0;
      ov_r   <= 1'b0;
      ph_r   <= 1'b0;
      step_r <= '0;
      g_r    <= '0;
      idx_r  <= '0;
    end else begin
      go_r <= 1'b0;
      ov_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          if (head.valid) begin
            item_r <= head.item;
            go_r   <= 1'b1;
            st_r   <= B_NZ;
          end
        end
        B_NZ: begin
          if (n_done) begin
            za_r    <= n_res;
            degen_r <= n_zero;
            step_r  <= '0;
            g_r     <= '0;
            ph_r    <= 1'b0;
            acc_r   <= '0;
            st_r    <= B_MAC;
          end
        end
        B_MAC: begin
          if (!ph_r) begin
            p_r  <= $signed(a_op) * $signed(b_op);
            ph_r <= 1'b1;
          end else begin
            ph_r   <= 1'b0;
            step_r <= step_r + 1'b1;
            if (op.last) begin
              acc_r <= '0;
              g_r   <= g_r + 1'b1;
              unique case (g_r)
                4'd0: cr_r[0] <= accv;
                4'd1: cr_r[1] <= accv;
                4'd2: cr_r[2] <= accv;
                4'd3: ya_r[0] <= rnd[Y_W-1:0];
                4'd4: ya_r[1] <= rnd[Y_W-1:0];
                4'd5: ya_r[2] <= rnd[Y_W-1:0];
                4'd6: t_r[0]  <= sat32(-$signed(rnd));
                4'd7: t_r[1]  <= sat32(-$signed(rnd));
                4'd8: t_r[2]  <= sat32(-$signed(rnd));
                default: acc_r <= '0;
              endcase
              if (g_r == 4'd2) begin
                go_r <= 1'b1;
                st_r <= B_NX;
              end
              if (step_r == MAC_LAST_STEP) begin
                idx_r <= '0;
                st_r  <= B_EMIT;
              end
            end else begin
              acc_r <= accv;
            end
          end
        end
        B_NX: begin
          if (n_done) begin
            xa_r    <= n_res;
            degen_r <= degen_r | n_zero;
            st_r    <= B_MAC;
          end
        end
        B_EMIT: begin
          ov_r  <= 1'b1;
          oi_r  <= idx_r;
          ovl_r <= word;
          ol_r  <= (idx_r == 4'd15);
          od_r  <= degen_r;
          idx_r <= idx_r + 1'b1;
          if (idx_r == 4'd15) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_entry_index = oi_r;
  assign out_entry_value = ovl_r;
  assign out_last_entry  = ol_r;
  assign out_degenerate  = od_r;

endmodule

@@ src/look_at_view_matrix.sv @@
// Right-handed look-at view matrix in signed Q16.16. Pulse start with busy low to hand in an
// eye, a target and an up vector; sixteen words follow on consecutive cycles, each marked by
// out_valid for one cycle, index 0 through 15, out_last_entry on index 15. The receiver
// cannot stall the output, so it must take every word as it appears. Two requests queue
// ahead of the datapath, so busy only rises when both queue slots are taken. Each request
// makes two passes through the shared normalize unit (one-bit alignment shifter, bit-serial
// square root, restoring divider over three components), which a zero-length vector skips,
// and uses the single multiply-accumulate unit before its words are output.
`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix
  import lav_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_eye_x,
  input  logic [31:0] in_eye_y,
  input  logic [31:0] in_eye_z,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_z,
  input  logic [31:0] in_up_x,
  input  logic [31:0] in_up_y,
  input  logic [31:0] in_up_z,
  output logic        out_valid,
  output logic [3:0]  out_entry_index,
  output logic [31:0] out_entry_value,
  output logic        out_last_entry,
  output logic        out_degenerate
);

  lav_head_t head;
  logic      pop;

  lav_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_eye_x    (in_eye_x),
    .in_eye_y    (in_eye_y),
    .in_eye_z    (in_eye_z),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .in_target_z (in_target_z),
    .in_up_x     (in_up_x),
    .in_up_y     (in_up_y),
    .in_up_z     (in_up_z),
    .pop         (pop),
    .head        (head)
  );

  lav_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry),
    .out_degenerate  (out_degenerate)
  );

  `LAV_ASSERT_NEXT(a_idx_step, out_valid && !out_last_entry, out_valid && (out_entry_index == $past(out_entry_index) + 4'd1), "output word index did not advance")
  `LAV_ASSERT_NEXT(a_run_end, out_valid && out_last_entry, !out_valid, "word emitted after last entry")
  `LAV_ASSERT_NOW(a_full_nonempty, busy, head.valid, "queue full but head empty")
  `LAV_ASSERT_NOW(a_no_pop_in_run, out_valid && !out_last_entry, !pop, "queue popped while a run is emitting")

endmodule

@@ test/tb_look_at_view_matrix.sv @@
module tb_look_at_view_matrix;
  import lav_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] tgt;
    logic [2:0][31:0] up;
  } camera_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
    logic        degen;
  } matrix_word_t;

  typedef longint vec3_t [3];

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  camera_t     cam;
  logic        out_valid;
  logic [3:0]  out_entry_index;
  logic [31:0] out_entry_value;
  logic        out_last_entry;
  logic        out_degenerate;

  matrix_word_t matrix_q[$];
  int           mismatches;
  bit           no_idle;

  look_at_view_matrix u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_eye_x        (cam.eye[0]),
    .in_eye_y        (cam.eye[1]),
    .in_eye_z        (cam.eye[2]),
    .in_target_x     (cam.tgt[0]),
    .in_target_y     (cam.tgt[1]),
    .in_target_z     (cam.tgt[2]),
    .in_up_x         (cam.up[0]),
    .in_up_y         (cam.up[1]),
    .in_up_z         (cam.up[2]),
    .out_valid       (out_valid),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry),
    .out_degenerate  (out_degenerate)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit [63:0] int_sqrt(input bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // return 1 when the vector has zero length
  function automatic bit unit_vec(input vec3_t c, output vec3_t o);
    bit [63:0] m[3];
    bit [63:0] mx;
    bit [63:0] sum;
    bit [63:0] len;
    bit [63:0] q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 16) + (len >> 1)) / len;
      o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic longint to_q16(input longint v);
    longint q;
    q = ((v < 0 ? -v : v) + 64'sd32768) >>> 16;
    return v < 0 ? -q : q;
  endfunction

  function automatic logic [31:0] neg_sat(input longint v);
    longint r;
    r = -to_q16(v);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict_view(input camera_t c);
    vec3_t eye, up, d, cr, xa, ya, za;
    longint t[3];
    longint m[16];
    bit degen;
    matrix_word_t w;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(c.eye[i]));
      up[i]  = longint'($signed(c.up[i]));
      d[i]   = eye[i] - longint'($signed(c.tgt[i]));
    end
    degen = unit_vec(d, za);
    cr[0] = up[1] * za[2] - up[2] * za[1];
    cr[1] = up[2] * za[0] - up[0] * za[2];
    cr[2] = up[0] * za[1] - up[1] * za[0];
    if (unit_vec(cr, xa)) degen = 1'b1;
    ya[0] = to_q16(za[1] * xa[2] - za[2] * xa[1]);
    ya[1] = to_q16(za[2] * xa[0] - za[0] * xa[2]);
    ya[2] = to_q16(za[0] * xa[1] - za[1] * xa[0]);
    t[0] = neg_sat(xa[0] * eye[0] + xa[1] * eye[1] + xa[2] * eye[2]);
    t[1] = neg_sat(ya[0] * eye[0] + ya[1] * eye[1] + ya[2] * eye[2]);
    t[2] = neg_sat(za[0] * eye[0] + za[1] * eye[1] + za[2] * eye[2]);
    for (int i = 0; i < 3; i++) begin
      m[4 * i]     = xa[i];
      m[4 * i + 1] = ya[i];
      m[4 * i + 2] = za[i];
      m[4 * i + 3] = 0;
      m[12 + i]    = t[i];
    end
    m[15] = longint'(ONE_Q16);
    for (int i = 0; i < 16; i++) begin
      w.index = i[3:0];
      w.value = m[i][31:0];
      w.last  = (i == 15);
      w.degen = degen;
      matrix_q.push_back(w);
    end
  endtask

  // called at a falling edge; leaves start high, returns at a falling edge
  task automatic send_camera(input camera_t c);
    cam   = c;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_view(c);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      start = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    matrix_word_t e;
    if (rst_n && out_valid) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: index %0d value %h", out_entry_index, out_entry_value);
      end else begin
        e = matrix_q.pop_front();
        if (out_entry_index !== e.index || out_entry_value !== e.value ||
            out_last_entry !== e.last || out_degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx %0d val %h last %b degen %b, got %0d %h %b %b",
                     e.index, e.value, e.last, e.degen, out_entry_index,
                     out_entry_value, out_last_entry, out_degenerate);
        end
      end
    end
  end

  function automatic logic [31:0] small_val();
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  function automatic camera_t rand_camera();
    camera_t c;
    logic [31:0] d;
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = k < 3 ? $urandom() : small_val();
      c.tgt[i] = k < 3 ? $urandom() : small_val();
      c.up[i]  = k < 3 ? $urandom() : small_val();
    end
    case (k)
      7: c.tgt = c.eye;
      8: for (int i = 0; i < 3; i++) begin
           // up along the view direction
           d = small_val() >>> 8;
           c.tgt[i] = c.eye[i] - d;
           c.up[i]  = d << 1;
         end
      9: for (int i = 0; i < 3; i++)
           if ($urandom_range(0, 1)) begin
             c.up[i]  = '0;
             c.tgt[i] = c.eye[i];
           end
      default: ;
    endcase
    return c;
  endfunction

  function automatic camera_t mk_cam(input logic [31:0] ex, ey, ez, tx, ty, tz,
                                     input logic [31:0] ux, uy, uz);
    camera_t c;
    c.eye = {ez, ey, ex};
    c.tgt = {tz, ty, tx};
    c.up  = {uz, uy, ux};
    return c;
  endfunction

  task automatic test_directed();
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    send_camera(mk_cam(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_camera(mk_cam(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    send_camera(mk_cam(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0));
    send_camera(mk_cam(0, 3 * ONE, 0, 0, 0, 0, 0, ONE, 0));
    send_camera(mk_cam(0, 0, 0, 0, 0, -ONE, 0, -7 * ONE, 0));
    send_camera(mk_cam(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV));
    send_camera(mk_cam(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV));
    send_camera(mk_cam(MINV, MINV, MINV, 0, 0, 0, 0, ONE, 0));
    send_camera(mk_cam(MAXV, MAXV, MAXV, 0, 0, 0, MINV, 0, MAXV));
    send_camera(mk_cam(MAXV, 0, MINV, MINV, 0, MAXV, 0, MAXV, 0));
    send_camera(mk_cam(1, 0, 0, 0, 0, 0, 0, 0, 1));
    send_camera(mk_cam(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 0));
    send_camera(mk_cam(ONE, ONE, ONE, -ONE, -ONE, -ONE, 2, 2, 2));
    send_camera(mk_cam(3, -5, 7, 0, 0, 0, ONE, ONE, 0));
    start = 1'b0;
  endtask

  task automatic test_burst(input int n);
    no_idle = 1'b1;
    repeat (n) send_camera(rand_camera());
    start = 1'b0;
  endtask

  task automatic test_random_gaps(input int n);
    no_idle = 1'b0;
    repeat (n) begin
      send_camera(rand_camera());
      sender_gap();
    end
    start = 1'b0;
  endtask

  task automatic test_drain();
    start = 1'b0;
    wait (matrix_q.size() == 0);
    @(negedge clk);
    send_camera(rand_camera());
    start = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    cam        = '0;
    mismatches = 0;
    no_idle    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random_gaps(100);
    test_drain();
    test_burst(60);
    test_random_gaps(85);
    wait (matrix_q.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && matrix_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/lav_pkg.sv
src/lav_front.sv
src/lav_norm.sv
src/lav_back.sv
src/look_at_view_matrix.sv
test/tb_look_at_view_matrix.sv
